// ===== rtl/oth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oth_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_INVALID   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_BEYOND    = 2'd3;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic capture;
    logic record;
    logic issue;
    logic hit;
    logic miss;
  } oth_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic eval_hit;
    logic pipe_valid;
  } oth_stat_t;

endpackage

`default_nettype wire

// ===== rtl/oth_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oth_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire              kind,
  input  oth_pkg::oth_stat_t st,
  output oth_pkg::oth_cmd_t  cmd,
  output logic             busy
);
  import oth_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RECORD = 3'b010,
    S_SEARCH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = (kind == KIND_LOOKUP) ? S_SEARCH : S_RECORD;
        end
      end
      S_RECORD: begin
        cmd.record = 1'b1;
        state_next = S_IDLE;
      end
      S_SEARCH: begin
        if (st.eval_hit) begin
          cmd.hit = 1'b1;
          state_next = S_IDLE;
        end else if (st.issue_done && !st.pipe_valid) begin
          cmd.miss = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.issue = !st.issue_done;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/oth_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module oth_dp #(
  parameter int DEPTH = oth_pkg::DEPTH_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  oth_pkg::oth_cmd_t  cmd,
  output oth_pkg::oth_stat_t st,
  input  wire signed [63:0]  stream_offset,
  input  wire signed [63:0]  stamp_in,
  input  wire signed [31:0]  margin_limit,
  output logic               done,
  output logic [1:0]         status,
  output logic [62:0]        stamp_out,
  output logic signed [31:0] distance
);
  import oth_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  logic [62:0] offset_store [DEPTH];
  logic [62:0] stamp_store  [DEPTH];

  logic [AW-1:0] oldest_pointer;
  logic [CW-1:0] entry_count;
  logic [62:0]   last_offset;

  logic [63:0]   query;
  logic [63:0]   stamp_l;
  logic [31:0]   limit_l;
  logic          reverse;
  logic [CW-1:0] issue_n;

  logic          pipe_valid;
  logic          first;
  logic [62:0]   cur_off;
  logic [62:0]   prev_off;
  logic [62:0]   cur_stamp;

  logic [CW-1:0] k_wide;
  logic [AW-1:0] k;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] rd_prev;
  logic [AW-1:0] k_rec;
  logic [AW:0]   rec_sum;
  logic [AW-1:0] wr_slot;
  logic          full;
  logic          pair_ok;
  logic          cap_reverse;
  logic          cur_ge_q;
  logic          prev_lt_q;
  logic          eval_hit;
  logic [31:0]   diff32;

  assign k_wide   = reverse ? (entry_count - CW'(1) - issue_n) : issue_n;
  assign k        = k_wide[AW-1:0];
  assign slot_sum = {1'b0, oldest_pointer} + {1'b0, k};
  assign rd_slot  = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : slot_sum[AW-1:0];
  assign rd_prev  = (rd_slot == '0) ? LAST_SLOT : (rd_slot - AW'(1));

  assign full     = (entry_count == FULL);
  assign k_rec    = entry_count[AW-1:0];
  assign rec_sum  = {1'b0, oldest_pointer} + {1'b0, k_rec};
  assign wr_slot  = full ? oldest_pointer :
                    ((rec_sum >= DEPTH_W) ? AW'(rec_sum - DEPTH_W) : rec_sum[AW-1:0]);
  assign pair_ok  = !query[63] && !stamp_l[63];

  // The lookup runs from the newest entry when last_offset < 2 * query.
  assign cap_reverse = !stream_offset[63] && (stream_offset != '0) &&
                       ({1'b0, last_offset} < {stream_offset[62:0], 1'b0});

  assign cur_ge_q  = query[63] || (cur_off >= query[62:0]);
  assign prev_lt_q = !query[63] && (prev_off < query[62:0]);
  assign eval_hit  = pipe_valid && cur_ge_q &&
                     (first || prev_lt_q || (prev_off > cur_off));
  assign diff32    = cur_off[31:0] - query[31:0];

  assign st.issue_done = (issue_n == entry_count);
  assign st.eval_hit   = eval_hit;
  assign st.pipe_valid = pipe_valid;

  always_ff @(posedge clk) begin
    cur_off   <= offset_store[rd_slot];
    prev_off  <= offset_store[rd_prev];
    cur_stamp <= stamp_store[rd_slot];
    if (cmd.record && pair_ok) begin
      offset_store[wr_slot] <= query[62:0];
      stamp_store[wr_slot]  <= stamp_l[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      query   <= stream_offset;
      stamp_l <= stamp_in;
      limit_l <= margin_limit;
      reverse <= cap_reverse;
    end
    if (cmd.issue) begin
      first <= (k == '0);
    end
    if (cmd.record) begin
      status    <= pair_ok ? STATUS_OK : STATUS_INVALID;
      stamp_out <= '0;
      distance  <= '0;
    end else if (cmd.hit) begin
      status    <= (!limit_l[31] && ($signed(diff32) > $signed(limit_l))) ?
                   STATUS_BEYOND : STATUS_OK;
      stamp_out <= cur_stamp;
      distance  <= diff32;
    end else if (cmd.miss) begin
      status    <= STATUS_NOT_FOUND;
      stamp_out <= '0;
      distance  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_pointer <= '0;
      entry_count    <= '0;
      last_offset    <= '0;
      issue_n        <= '0;
      pipe_valid     <= 1'b0;
      done           <= 1'b0;
    end else begin
      pipe_valid <= cmd.issue;
      done       <= cmd.record || cmd.hit || cmd.miss;
      if (cmd.capture) begin
        issue_n <= '0;
      end else if (cmd.issue) begin
        issue_n <= issue_n + CW'(1);
      end
      if (cmd.record && pair_ok) begin
        last_offset <= query[62:0];
        if (full) begin
          oldest_pointer <= (oldest_pointer == LAST_SLOT) ? '0 : (oldest_pointer + AW'(1));
        end else begin
          entry_count <= entry_count + CW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/offset_timestamp_history_table.sv =====
// Keeps the last DEPTH (offset, timestamp) pairs and answers lookups over them. An item is
// taken when start is high and busy is low; its single result appears for exactly one cycle
// with done high, and it must be captured then because the block cannot be stalled. A record
// beat passes through the RECORD state and gives its result on the registered done. A lookup walks
// the live entries one per cycle through the two read ports of the offset store and ends early
// at the first matching entry. busy stays high until the result is presented, and a new item
// may be started in the cycle done is high.
`timescale 1ns / 1ps
`default_nettype none

module offset_timestamp_history_table #(
  parameter int DEPTH = oth_pkg::DEPTH_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire                kind,
  input  wire signed [63:0]  stream_offset,
  input  wire signed [63:0]  stamp_in,
  input  wire signed [31:0]  margin_limit,
  output logic               done,
  output logic [1:0]         status,
  output logic [62:0]        stamp_out,
  output logic signed [31:0] distance
);
  import oth_pkg::*;

  oth_cmd_t  cmd;
  oth_stat_t st;

  oth_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  oth_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .stream_offset (stream_offset),
    .stamp_in      (stamp_in),
    .margin_limit  (margin_limit),
    .done          (done),
    .status        (status),
    .stamp_out     (stamp_out),
    .distance      (distance)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat presented while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result beats in a row");

  a_invalid_record: assert property (@(posedge clk) disable iff (rst)
      (done && (status == STATUS_INVALID)) |-> ((stamp_out == '0) && (distance == '0)))
    else $error("invalid pair result carries data");

endmodule

`default_nettype wire
